@@ sv/bnms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants of the box non-maximum suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int MAX_BOXES_TOP = 64;
    localparam int CNT_W         = $clog2(MAX_BOXES_TOP + 1);
    localparam int THR_W         = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
    localparam int COORD_W       = 16;
    localparam int SIZE_W        = 15;
    localparam int AREA_W        = 2 * SIZE_W;

    // one stored rectangle, area worked out on load
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [AREA_W-1:0]         area;
    } t_box;

    // one closed set waiting for the back end
    typedef struct packed {
        logic             valid;
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_set;

endpackage

@@ sv/bnms_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_if
// Request channels of the block: incoming rectangles and surviving ones.
// ----------------------------------------------------------------------------
interface bnms_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic               last_box;

    modport source (output valid, box_x, box_y, box_width, box_height, last_box,
                    input ready);
    modport sink   (input valid, box_x, box_y, box_width, box_height, last_box,
                    output ready);
endinterface

interface bnms_keep_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] keep_x;
    logic signed [15:0] keep_y;
    logic [14:0]        keep_width;
    logic [14:0]        keep_height;
    logic               keep_last;
    logic               set_overflow;

    modport source (output valid, keep_x, keep_y, keep_width, keep_height, keep_last,
                    set_overflow, input ready);
    modport sink   (input valid, keep_x, keep_y, keep_width, keep_height, keep_last,
                    set_overflow, output ready);
endinterface

@@ sv/bnms_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/bnms_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_front
// Loads rectangles into the current bank and queues closed sets.
// ----------------------------------------------------------------------------
module bnms_front #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bnms_box_if.sink                       i_box,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_BOXES):0]     o_wr_addr,
    output bnms_pkg::t_box                 o_wr_data,
    output bnms_pkg::t_set                 o_set,
    input  logic                           i_pop
);
    import bnms_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_qent;

    logic          r_bank;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    t_qent         r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_qcnt;

    logic          accept;
    logic          room;
    logic          push;
    logic [CW-1:0] n_count;
    logic          n_ovf;

    assign i_box.ready = (r_qcnt != 2'd2);
    assign accept      = i_box.valid && i_box.ready;
    assign room        = (r_count < CW'(MAX_BOXES));
    assign push        = accept && i_box.last_box;
    assign n_count     = room ? r_count + CW'(1) : r_count;
    assign n_ovf       = r_ovf | ~room;

    assign o_wr_en          = accept && room;
    assign o_wr_addr        = {r_bank, r_count[IW-1:0]};
    assign o_wr_data.x      = i_box.box_x;
    assign o_wr_data.y      = i_box.box_y;
    assign o_wr_data.w      = i_box.box_width;
    assign o_wr_data.h      = i_box.box_height;
    assign o_wr_data.area   = AREA_W'(i_box.box_width) * AREA_W'(i_box.box_height);

    assign o_set.valid = (r_qcnt != 2'd0);
    assign o_set.bank  = r_q[r_rp].bank;
    assign o_set.count = r_q[r_rp].count;
    assign o_set.ovf   = r_q[r_rp].ovf;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{bank: r_bank, count: CNT_W'(n_count), ovf: n_ovf};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_qcnt  <= 2'd0;
        end else begin
            if (accept) begin
                r_count <= push ? '0 : n_count;
                r_ovf   <= push ? 1'b0 : n_ovf;
            end
            if (push) begin
                r_bank <= ~r_bank;
                r_wp   <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_qcnt <= r_qcnt + 2'(push) - 2'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    // the set being filled never shares a bank with the one still queued
    a_bank_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcnt == 2'd1 && push) |-> (r_q[r_rp].bank != r_bank))
        else $error("front: bank collision");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !room |-> r_count == CW'(MAX_BOXES))
        else $error("front: store count out of range");
    a_qcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt != 2'd3)
        else $error("front: set queue overrun");
`endif
endmodule

@@ sv/bnms_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_back
// Ranks a set by area, runs greedy overlap suppression and sends survivors.
// ----------------------------------------------------------------------------
module bnms_back #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bnms_pkg::THR_W-1:0]    i_thr,
    input  bnms_pkg::t_set                i_set,
    output logic                          o_pop,
    output logic [$clog2(MAX_BOXES):0]    o_rd_addr,
    input  bnms_pkg::t_box                i_rd_data,
    bnms_keep_if.source                   o_keep
);
    import bnms_pkg::*;

    localparam int IW    = $clog2(MAX_BOXES);
    localparam int CW    = $clog2(MAX_BOXES + 1);
    localparam int ODEPTH = 2 ** IW;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_RK_LD   = 11'b00000000010,
        S_RK_WAIT = 11'b00000000100,
        S_RK_SCAN = 11'b00000001000,
        S_RK_WR   = 11'b00000010000,
        S_SP_ORD  = 11'b00000100000,
        S_SP_OW   = 11'b00001000000,
        S_SP_BW   = 11'b00010000000,
        S_SP_EMIT = 11'b00100000000,
        S_SP_SCAN = 11'b01000000000,
        S_FLUSH   = 11'b10000000000
    } t_state;

    t_state          r_state;
    logic            r_bank;
    logic [CW-1:0]   r_n;
    logic            r_ovf;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [CW-1:0]   r_rank;
    logic [AREA_W-1:0] r_ai;
    logic            r_pv;
    logic [CW-1:0]   r_pj;
    t_box            r_cur;
    t_box            r_pend;
    logic            r_pvld;
    logic [ODEPTH-1:0] r_del;

    // output register
    logic            r_ov;
    t_box            r_obox;
    logic            r_olast;
    logic            r_oovf;

    // overlap pipeline
    logic            r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic [IW-1:0]   r_b2, r_b3, r_b4, r_b5, r_b6;
    logic [16:0]     r_iw3, r_ih3;
    logic [AREA_W:0] r_as3, r_as4;
    logic [33:0]     r_inter4, r_inter5, r_inter6;
    logic signed [34:0] r_un5;
    logic [47:0]     r_prod6;
    logic            r_upos6, r_uzero6;

    logic [IW-1:0]   ord_raddr;
    logic [IW-1:0]   ord_rdata;
    logic            ord_we;
    logic            out_free;
    logic            ov_load;
    logic            pipe_busy;
    logic            last_i;
    logic            hit;

    logic signed [17:0] ax2, bx2, ay2, by2, x2, y2;
    logic signed [15:0] x1, y1;
    logic signed [18:0] dx, dy;

    assign out_free  = !r_ov || o_keep.ready;
    assign ov_load   = ((r_state == S_SP_EMIT) && r_pvld && out_free)
                       || ((r_state == S_FLUSH) && out_free);
    assign pipe_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5 | r_v6;
    assign last_i    = (r_i + CW'(1) == r_n);
    assign ord_we    = (r_state == S_RK_WR);
    assign ord_raddr = (r_state == S_SP_ORD) ? r_i[IW-1:0] : r_j[IW-1:0];
    assign o_pop     = (r_state == S_FLUSH) && out_free;

    always_comb begin
        if (r_state == S_RK_LD) begin
            o_rd_addr = {r_bank, r_i[IW-1:0]};
        end else if (r_state == S_RK_SCAN) begin
            o_rd_addr = {r_bank, r_j[IW-1:0]};
        end else begin
            o_rd_addr = {r_bank, ord_rdata};
        end
    end

    bnms_ram #(.WIDTH(IW), .DEPTH(ODEPTH)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_rank[IW-1:0]),
        .i_wdata (r_i[IW-1:0]),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // intersection extents against the box under test
    always_comb begin
        ax2 = 18'(r_cur.x) + $signed({3'b000, r_cur.w});
        bx2 = 18'(i_rd_data.x) + $signed({3'b000, i_rd_data.w});
        ay2 = 18'(r_cur.y) + $signed({3'b000, r_cur.h});
        by2 = 18'(i_rd_data.y) + $signed({3'b000, i_rd_data.h});
        x1  = (r_cur.x > i_rd_data.x) ? r_cur.x : i_rd_data.x;
        y1  = (r_cur.y > i_rd_data.y) ? r_cur.y : i_rd_data.y;
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        dx  = 19'(x2) - 19'(x1) + 19'sd1;
        dy  = 19'(y2) - 19'(y1) + 19'sd1;
    end

    assign hit = r_v6 && (r_upos6 ? ({r_inter6, 16'b0} > 50'(r_prod6))
                                  : (r_uzero6 && (r_inter6 != '0)));

    // overlap datapath, one pair a cycle
    always_ff @(posedge i_clk) begin
        r_b2     <= ord_rdata;
        r_b3     <= r_b2;
        r_iw3    <= (dx > 19'sd0) ? dx[16:0] : '0;
        r_ih3    <= (dy > 19'sd0) ? dy[16:0] : '0;
        r_as3    <= (AREA_W + 1)'(r_cur.area) + (AREA_W + 1)'(i_rd_data.area);
        r_b4     <= r_b3;
        r_inter4 <= 34'(r_iw3) * 34'(r_ih3);
        r_as4    <= r_as3;
        r_b5     <= r_b4;
        r_inter5 <= r_inter4;
        r_un5    <= $signed({4'b0000, r_as4}) - $signed({1'b0, r_inter4});
        r_b6     <= r_b5;
        r_inter6 <= r_inter5;
        r_prod6  <= 48'(i_thr) * 48'(r_un5[30:0]);
        r_upos6  <= !r_un5[34] && (r_un5 != '0);
        r_uzero6 <= (r_un5 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RK_WAIT) begin
            r_ai <= i_rd_data.area;
        end
        if (r_state == S_RK_SCAN) begin
            r_pj <= r_j;
        end
        if (r_state == S_SP_BW) begin
            r_cur <= i_rd_data;
        end
        if (r_state == S_IDLE) begin
            r_bank <= i_set.bank;
            r_n    <= i_set.count[CW-1:0];
            r_ovf  <= i_set.ovf;
        end
        if (r_state == S_SP_EMIT && (!r_pvld || out_free)) begin
            r_pend <= r_cur;
        end
        if (r_state == S_SP_EMIT && r_pvld && out_free) begin
            r_obox  <= r_pend;
            r_olast <= 1'b0;
            r_oovf  <= r_ovf;
        end
        if (r_state == S_FLUSH && out_free) begin
            r_obox  <= r_pend;
            r_olast <= 1'b1;
            r_oovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_rank  <= '0;
            r_pv    <= 1'b0;
            r_pvld  <= 1'b0;
            r_del   <= '0;
            r_ov    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_SP_SCAN) && (r_j < r_n);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            if (hit) begin
                r_del[r_b6] <= 1'b1;
            end
            if (ov_load) begin
                r_ov <= 1'b1;
            end else if (o_keep.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_set.valid) begin
                        r_i     <= '0;
                        r_del   <= '0;
                        r_state <= S_RK_LD;
                    end
                end
                S_RK_LD: begin
                    r_state <= S_RK_WAIT;
                end
                S_RK_WAIT: begin
                    r_rank  <= '0;
                    r_j     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_RK_SCAN;
                end
                S_RK_SCAN: begin
                    r_pv <= (r_j < r_n);
                    if (r_j < r_n) begin
                        r_j <= r_j + CW'(1);
                    end
                    // earlier box wins a tie
                    if (r_pv && ((i_rd_data.area > r_ai)
                                 || (i_rd_data.area == r_ai && r_pj < r_i))) begin
                        r_rank <= r_rank + CW'(1);
                    end
                    if (r_j == r_n && !r_pv) begin
                        r_state <= S_RK_WR;
                    end
                end
                S_RK_WR: begin
                    r_i     <= last_i ? '0 : r_i + CW'(1);
                    r_state <= last_i ? S_SP_ORD : S_RK_LD;
                end
                S_SP_ORD: begin
                    r_state <= S_SP_OW;
                end
                S_SP_OW: begin
                    if (r_del[ord_rdata]) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= last_i ? S_FLUSH : S_SP_ORD;
                    end else begin
                        r_state <= S_SP_BW;
                    end
                end
                S_SP_BW: begin
                    r_state <= S_SP_EMIT;
                end
                S_SP_EMIT: begin
                    // the previous survivor goes out once the next one is known
                    if (!r_pvld || out_free) begin
                        r_pvld  <= 1'b1;
                        r_j     <= r_i + CW'(1);
                        r_state <= S_SP_SCAN;
                    end
                end
                S_SP_SCAN: begin
                    if (r_j < r_n) begin
                        r_j  <= r_j + CW'(1);
                    end else if (!pipe_busy) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= last_i ? S_FLUSH : S_SP_ORD;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_pvld  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_keep.valid        = r_ov;
    assign o_keep.keep_x       = r_obox.x;
    assign o_keep.keep_y       = r_obox.y;
    assign o_keep.keep_width   = r_obox.w;
    assign o_keep.keep_height  = r_obox.h;
    assign o_keep.keep_last    = r_olast;
    assign o_keep.set_overflow = r_oovf;

`ifndef NO_ASSERTIONS
    // the first sorted box always survives, so a set never ends empty
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH |-> r_pvld)
        else $error("back: no survivor at end of set");
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RK_WR |-> r_rank < r_n)
        else $error("back: rank beyond set size");
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_SP_SCAN |-> !r_v1 && !r_v2)
        else $error("back: overlap pipeline active outside scan");
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_free) |=> r_ov && r_olast)
        else $error("back: final survivor not flagged");
`endif
endmodule

@@ sv/box_non_max_suppression.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Greedy IoU non-maximum suppression over sets of up to MAX_BOXES rectangles.
// ----------------------------------------------------------------------------
// Rectangles are taken one per cycle into one of two banks of the box store,
// except while two closed sets are queued; the request with last_box set
// closes a set, and loading of the next set carries on in the other bank
// while the back end works on this one. The back end ranks a set by area
// through the single read port of the box store and then runs suppression
// over it; it holds while the output is stalled. Survivors leave in area
// order, largest first, with keep_last on the final one and set_overflow on
// all of them when boxes beyond capacity were dropped.
module box_non_max_suppression #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bnms_pkg::THR_W-1:0] i_cfg_wr_data,
    bnms_box_if.sink                   i_box,
    bnms_keep_if.source                o_keep
);
    import bnms_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);

    logic [THR_W-1:0] r_thr;
    logic             wr_en;
    logic [IW:0]      wr_addr;
    t_box             wr_data;
    logic [IW:0]      rd_addr;
    logic [$bits(t_box)-1:0] rd_raw;
    t_set             set_head;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    bnms_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_box     (i_box),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_set     (set_head),
        .i_pop     (pop)
    );

    // two banks: one filling, one being worked on
    bnms_ram #(.WIDTH($bits(t_box)), .DEPTH(2 ** (IW + 1))) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_raw)
    );

    bnms_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thr     (r_thr),
        .i_set     (set_head),
        .o_pop     (pop),
        .o_rd_addr (rd_addr),
        .i_rd_data (t_box'(rd_raw)),
        .o_keep    (o_keep)
    );
endmodule

@@ sim/tb_box_non_max_suppression.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_non_max_suppression
// Self-checking bench for greedy box suppression: sets of rectangles are sent
// with random gaps, survivors are predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
module tb_box_non_max_suppression;
    import bnms_pkg::*;

    localparam int NBOX      = 64;
    localparam int CYC_LIMIT = 2000000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic               last;
    } t_rect_req;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic               last;
        logic               ovf;
    } t_survivor;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [THR_W-1:0] i_cfg_wr_data;

    bnms_box_if  box_ch ();
    bnms_keep_if keep_ch ();

    box_non_max_suppression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_box         (box_ch.sink),
        .o_keep        (keep_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_rect_req pending_rects[$];
    t_survivor expected_survivors[$];
    t_rect_req set_rects[$];
    logic [THR_W-1:0] threshold;
    int  mismatches;
    int  send_gap;
    int  recv_gap;
    bit  hold_sender;
    longint cycles;

    // ---------------------------------------------------------------- predictor
    function automatic bit overlaps_enough(t_rect_req a, t_rect_req b, logic [THR_W-1:0] thr);
        longint x1, y1, x2, y2, iw, ih, inter, uni;
        x1 = (a.x > b.x) ? a.x : b.x;
        y1 = (a.y > b.y) ? a.y : b.y;
        x2 = ((a.x + longint'(a.w)) < (b.x + longint'(b.w))) ?
             a.x + longint'(a.w) : b.x + longint'(b.w);
        y2 = ((a.y + longint'(a.h)) < (b.y + longint'(b.h))) ?
             a.y + longint'(a.h) : b.y + longint'(b.h);
        iw = (x2 - x1 + 1 > 0) ? x2 - x1 + 1 : 0;
        ih = (y2 - y1 + 1 > 0) ? y2 - y1 + 1 : 0;
        inter = iw * ih;
        uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
        if (uni < 0) return 1'b0;
        if (uni == 0) return inter > 0;
        return inter * 65536 > longint'(thr) * uni;
    endfunction

    // stores one request; on a closing one, works out the survivors of the set
    task automatic predict_survivors(t_rect_req r, ref bit ovf_seen);
        int order[$];
        bit gone[];
        int n, j;
        longint ar;
        t_survivor s;
        if (set_rects.size() < NBOX) set_rects.insert(set_rects.size(), r);
        else ovf_seen = 1'b1;
        if (!r.last) return;
        n = set_rects.size();
        for (int i = 0; i < n; i++) begin
            ar = longint'(set_rects[i].w) * set_rects[i].h;
            j = order.size();
            while (j > 0 && longint'(set_rects[order[j-1]].w) * set_rects[order[j-1]].h < ar)
                j--;
            order.insert(j, i);
        end
        gone = new[n];
        for (int i = 0; i < n; i++) begin
            if (!gone[order[i]]) begin
                for (int k = i + 1; k < n; k++)
                    if (overlaps_enough(set_rects[order[i]], set_rects[order[k]], threshold))
                        gone[order[k]] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (!gone[order[i]]) begin
                s.x = set_rects[order[i]].x;
                s.y = set_rects[order[i]].y;
                s.w = set_rects[order[i]].w;
                s.h = set_rects[order[i]].h;
                s.last = 1'b0;
                s.ovf = ovf_seen;
                expected_survivors.insert(expected_survivors.size(), s);
            end
        end
        expected_survivors[expected_survivors.size()-1].last = 1'b1;
        set_rects.delete();
        ovf_seen = 1'b0;
    endtask

    // ---------------------------------------------------------------- driver
    bit ovf_flag;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_ch.valid <= 1'b0;
            send_gap <= $urandom_range(0, 6);
        end else if (box_ch.valid && !box_ch.ready) begin
            // hold the request
        end else begin
            if (box_ch.valid)
                predict_survivors({box_ch.box_x, box_ch.box_y, box_ch.box_width,
                                   box_ch.box_height, box_ch.last_box}, ovf_flag);
            if (send_gap > 0 || hold_sender || pending_rects.size() == 0) begin
                box_ch.valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                t_rect_req r;
                r = pending_rects.pop_front();
                box_ch.valid      <= 1'b1;
                box_ch.box_x      <= r.x;
                box_ch.box_y      <= r.y;
                box_ch.box_width  <= r.w;
                box_ch.box_height <= r.h;
                box_ch.last_box   <= r.last;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            keep_ch.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (keep_ch.valid && keep_ch.ready) begin
                t_survivor got, want;
                got = {keep_ch.keep_x, keep_ch.keep_y, keep_ch.keep_width,
                       keep_ch.keep_height, keep_ch.keep_last, keep_ch.set_overflow};
                if (expected_survivors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected survivor %p", got);
                end else begin
                    want = expected_survivors.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("survivor mismatch: expected %p actual %p", want, got);
                    end
                end
                recv_gap <= $urandom_range(0, 6);
                keep_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                keep_ch.ready <= 1'b0;
            end else begin
                keep_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("box_non_max_suppression regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic t_rect_req rand_rect(bit last);
        t_rect_req r;
        r.x = 16'($urandom);
        r.y = 16'($urandom);
        r.w = 15'($urandom);
        r.h = 15'($urandom);
        r.last = last;
        return r;
    endfunction

    // clustered boxes so that suppression actually happens
    task automatic push_cluster_set(int n);
        t_rect_req r;
        int cx, cy, sz;
        cx = $urandom_range(0, 400) - 200;
        cy = $urandom_range(0, 400) - 200;
        sz = ($urandom_range(0, 4) == 0) ? 32767 : 60;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: r = rand_rect(1'b0);
                1: begin
                    r.x = 16'(cx); r.y = 16'(cy); r.w = 15'd20; r.h = 15'd20;
                end
                default: begin
                    r.x = 16'(cx + $urandom_range(0, 30) - 15);
                    r.y = 16'(cy + $urandom_range(0, 30) - 15);
                    r.w = 15'($urandom_range(0, sz));
                    r.h = 15'($urandom_range(0, sz));
                end
            endcase
            r.last = (i == n - 1);
            pending_rects.insert(pending_rects.size(), r);
        end
    endtask

    task automatic wait_idle();
        while (pending_rects.size() != 0 || box_ch.valid) @(posedge i_clk);
        while (expected_survivors.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        threshold     <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [THR_W-1:0] thr_list[5];
        mismatches = 0;
        cycles = 0;
        ovf_flag = 1'b0;
        hold_sender = 1'b0;
        threshold = THR_RESET;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        box_ch.valid = 1'b0;
        box_ch.box_x = '0;
        box_ch.box_y = '0;
        box_ch.box_width = '0;
        box_ch.box_height = '0;
        box_ch.last_box = 1'b0;
        keep_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single box, extremes, identical pair, zero-size pair
        pending_rects.insert(pending_rects.size(),
                             {16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 1'b1});
        pending_rects.insert(pending_rects.size(),
                             {16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sh8000, 16'sh8000, 15'h0, 15'h0, 1'b1});
        pending_rects.insert(pending_rects.size(),
                             {16'sd10, 16'sd10, 15'd5, 15'd5, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sd10, 16'sd10, 15'd5, 15'd5, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sd100, 16'sd100, 15'd0, 15'd0, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sd0, 16'sd0, 15'd3, 15'd3, 1'b0});
        pending_rects.insert(pending_rects.size(),
                             {16'sd500, 16'sd500, 15'd3, 15'd3, 1'b1});
        wait_idle();

        // overflow: 66 boxes with the closing one dropped
        hold_sender = 1'b1;
        push_cluster_set(66);
        hold_sender = 1'b0;
        wait_idle();

        thr_list = '{17'd0, 17'd65536, 17'h1ffff, 17'd1, 17'd32768};
        foreach (thr_list[t]) begin
            write_threshold(thr_list[t]);
            for (int s = 0; s < 8; s++)
                push_cluster_set($urandom_range(1, 8));
            if (t == 2) begin
                // sender waits for every survivor before carrying on
                while (pending_rects.size() != 0 || box_ch.valid) @(posedge i_clk);
                hold_sender = 1'b1;
                while (expected_survivors.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
                push_cluster_set(3);
            end
            wait_idle();
        end
        write_threshold(17'($urandom_range(0, 131071)));
        for (int s = 0; s < 6; s++)
            push_cluster_set($urandom_range(1, 6));
        wait_idle();

        if (mismatches == 0 && expected_survivors.size() == 0) begin
            $display("box_non_max_suppression regression: pass");
        end else begin
            $display("box_non_max_suppression regression: fail");
        end
        $finish;
    end

endmodule
